// ----- rtl/mme_pkg.sv -----
package mme_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam int VAL_W  = 32;
	localparam int IDX_FW = 3;
	localparam int CFG_W  = 4;
	localparam int CFG_IW = 2;

	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(4);

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_MUL    = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ROWS_A = 2'd0,
		CFG_INNER  = 2'd1,
		CFG_COLS_B = 2'd2,
		CFG_SPARE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic acc_vld;
		logic acc_first;
		logic load;
		logic shift;
	} cell_ctl_t;

	// last index of a dimension: 0 acts as 1, above the maximum acts as the maximum
	function automatic int dim_last(input logic [CFG_W-1:0] v, input int max_dim);
		int n;
		n = int'(v);
		if (n < 1) n = 1;
		if (n > max_dim) n = max_dim;
		return n - 1;
	endfunction

endpackage

// ----- rtl/mme_if.sv -----
interface mme_in_if;
	import mme_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              opcode;
	logic [IDX_FW-1:0]       row_index;
	logic [IDX_FW-1:0]       col_index;
	logic signed [VAL_W-1:0] element_value;

	modport source (output valid, opcode, row_index, col_index, element_value, input ready);
	modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mme_out_if;
	import mme_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] product_value;
	logic [IDX_FW-1:0]       out_row;
	logic [IDX_FW-1:0]       out_col;
	logic                    last_element;

	modport source (output valid, product_value, out_row, out_col, last_element, input ready);
	modport sink (input valid, product_value, out_row, out_col, last_element, output ready);
endinterface

// ----- rtl/mme_cell.sv -----
module mme_cell #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF,
	parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF,
	parameter int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                        clk,
	input  logic                        b_we,
	input  logic [IDX_W-1:0]            b_waddr,
	input  logic signed [ELEM_BITS-1:0] b_wdata,
	input  logic [IDX_W-1:0]            b_raddr,
	input  logic signed [ELEM_BITS-1:0] a_s1,
	input  mme_pkg::cell_ctl_t          ctl,
	input  logic signed [ELEM_BITS-1:0] shift_in,
	output logic signed [ELEM_BITS-1:0] shift_out
);
	import mme_pkg::*;

	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int ACC_W  = PROD_W + 4;
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W-ELEM_BITS+1){1'b0}}, {(ELEM_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W-ELEM_BITS+1){1'b1}}, {(ELEM_BITS-1){1'b0}}};

	logic signed [ELEM_BITS-1:0] b_mem [MAX_DIM];
	logic signed [ELEM_BITS-1:0] b_s1;
	logic signed [PROD_W-1:0]    prod_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     shifted;
	logic signed [ELEM_BITS-1:0] sat;
	logic signed [ELEM_BITS-1:0] out_q;

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[b_waddr] <= b_wdata;
		end
		b_s1 <= b_mem[b_raddr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_vld) begin
			if (ctl.acc_first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// floor shift, then clip to the element range
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		if (shifted > SAT_MAX) begin
			sat = SAT_MAX[ELEM_BITS-1:0];
		end else if (shifted < SAT_MIN) begin
			sat = SAT_MIN[ELEM_BITS-1:0];
		end else begin
			sat = shifted[ELEM_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			out_q <= sat;
		end else if (ctl.shift) begin
			out_q <= shift_in;
		end
	end

	assign shift_out = out_q;

endmodule

// ----- rtl/mme_ctrl.sv -----
module mme_ctrl #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
	parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mme_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_accept,
	input  logic [1:0]                   in_op,
	input  logic                         out_accept,
	output logic                         in_ready,
	output logic                         out_valid,
	output logic                         out_last,
	output logic [IDX_W-1:0]             row,
	output logic [IDX_W-1:0]             col,
	output logic [IDX_W-1:0]             k_idx,
	output mme_pkg::cell_ctl_t           ctl
);
	import mme_pkg::*;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} pipe_t;

	state_t           state_q, state_d;
	logic [CFG_W-1:0] rows_q, inner_q, cols_q;
	logic [IDX_W-1:0] r_q, c_q, k_q;
	logic [IDX_W-1:0] r_last, k_last, c_last;
	pipe_t            p_s1, p_s2;
	logic             load_s3;
	logic             issue;

	assign r_last = IDX_W'(dim_last(rows_q, MAX_DIM));
	assign k_last = IDX_W'(dim_last(inner_q, MAX_DIM));
	assign c_last = IDX_W'(dim_last(cols_q, MAX_DIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROWS_A: rows_q  <= cfg_data;
				CFG_INNER:  inner_q <= cfg_data;
				CFG_COLS_B: cols_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_accept && opcode_t'(in_op) == OP_MUL) state_d = ST_MAC;
			ST_MAC:  if (k_q == k_last) state_d = ST_WAIT;
			ST_WAIT: if (load_s3) state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_accept && c_q == c_last) begin
					state_d = (r_q == r_last) ? ST_IDLE : ST_MAC;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		issue     = (state_q == ST_MAC);
		out_last  = (r_q == r_last) && (c_q == c_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			p_s1    <= '0;
			p_s2    <= '0;
			load_s3 <= 1'b0;
		end else begin
			state_q <= state_d;
			p_s1    <= '{vld: issue, first: (k_q == '0), last: (k_q == k_last)};
			p_s2    <= p_s1;
			load_s3 <= p_s2.vld && p_s2.last;
			if (state_q == ST_IDLE) begin
				r_q <= '0;
				c_q <= '0;
				k_q <= '0;
			end else if (issue) begin
				k_q <= (k_q == k_last) ? '0 : k_q + 1'b1;
			end else if (state_q == ST_EMIT && out_accept) begin
				if (c_q == c_last) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	assign row   = r_q;
	assign col   = c_q;
	assign k_idx = k_q;
	assign ctl   = '{acc_vld: p_s2.vld, acc_first: p_s2.first, load: load_s3,
		shift: (state_q == ST_EMIT) && out_accept};

endmodule

// ----- rtl/matrix_multiply_engine.sv -----
// Load words: one per cycle while idle, no result.
// Compute word: per result row, multiply-accumulate over inner_size in the column cells
// (operand, product, accumulator registers), then cols_b result words, one per ready cycle.
// Input is held off while a compute word is in progress; the next word is taken
// the cycle after the final result word leaves.
// Reset clears control and size registers (4x4x4); element stores are undefined until loaded.
module matrix_multiply_engine #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF,
	parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mme_in_if.sink                     in_item,
	mme_out_if.source                  out_item,
	input  logic                       cfg_we,
	input  logic [mme_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]  cfg_data
);
	import mme_pkg::*;

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int A_AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
	localparam int A_DEPTH = MAX_DIM * MAX_DIM;

	logic                        in_acc, out_acc, out_valid, out_last, in_ready;
	logic [IDX_W-1:0]            row, col, k_idx;
	cell_ctl_t                   ctl;
	logic                        load_ok, ld_a, ld_b;
	logic [IDX_W-1:0]            ld_row, ld_col;
	logic signed [ELEM_BITS-1:0] ld_val;
	logic signed [ELEM_BITS-1:0] a_mem [A_DEPTH];
	logic signed [ELEM_BITS-1:0] a_s1;
	logic signed [ELEM_BITS-1:0] chain [MAX_DIM+1];

	assign in_acc  = in_item.valid && in_ready;
	assign out_acc = out_valid && out_item.ready;

	assign load_ok = (int'(in_item.row_index) < MAX_DIM) && (int'(in_item.col_index) < MAX_DIM);
	assign ld_a    = in_acc && load_ok && opcode_t'(in_item.opcode) == OP_LOAD_A;
	assign ld_b    = in_acc && load_ok && opcode_t'(in_item.opcode) == OP_LOAD_B;
	assign ld_row  = in_item.row_index[IDX_W-1:0];
	assign ld_col  = in_item.col_index[IDX_W-1:0];
	assign ld_val  = in_item.element_value[ELEM_BITS-1:0];

	mme_ctrl #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_accept(in_acc), .in_op(in_item.opcode), .out_accept(out_acc),
		.in_ready, .out_valid, .out_last, .row, .col, .k_idx, .ctl
	);

	always_ff @(posedge clk) begin
		if (ld_a) begin
			a_mem[A_AW'(int'(ld_row) * MAX_DIM + int'(ld_col))] <= ld_val;
		end
		a_s1 <= a_mem[A_AW'(int'(row) * MAX_DIM + int'(k_idx))];
	end

	// cell j holds column j of B; results shift toward cell 0
	assign chain[MAX_DIM] = '0;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		mme_cell #(
			.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)
		) u_cell (
			.clk,
			.b_we(ld_b && ld_col == IDX_W'(j)),
			.b_waddr(ld_row), .b_wdata(ld_val), .b_raddr(k_idx),
			.a_s1, .ctl,
			.shift_in(chain[j+1]), .shift_out(chain[j])
		);
	end

	assign in_item.ready          = in_ready;
	assign out_item.valid         = out_valid;
	assign out_item.product_value = VAL_W'(chain[0]);
	assign out_item.out_row       = IDX_FW'(row);
	assign out_item.out_col       = IDX_FW'(col);
	assign out_item.last_element  = out_last;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_item.ready && out_item.valid))
		else $error("input taken while results pending");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_item.valid && out_item.ready && out_item.last_element |=> in_item.ready)
		else $error("not idle after last result word");
	a_load_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !out_item.valid && !in_item.ready)
		else $error("result load outside accumulate wait");
`endif

endmodule
